/* design/arq_pkg.sv */
// ----------------------------------------------------------------------------
// ARQ retransmit queue package
// Shared types and constants of the retransmit queue.
// ----------------------------------------------------------------------------
`default_nettype none
package arq_pkg;
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 32;
   localparam logic [31:0] RESET_INTERVAL = 32'd200000;
   localparam logic [31:0] RESET_GIVE_UP  = 32'd5000000;

   typedef enum logic [1:0] {
      MODE_SEND  = 2'd0,
      MODE_ACK   = 2'd1,
      MODE_CLOSE = 2'd2,
      MODE_POLL  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_QUEUED      = 3'd0,
      ST_FULL        = 3'd1,
      ST_ACKED       = 3'd2,
      ST_MISSING     = 3'd3,
      ST_PURGED      = 3'd4,
      ST_RESEND      = 3'd5,
      ST_RESEND_LAST = 3'd6,
      ST_IDLE        = 3'd7
   } status_type;

   typedef enum logic [0:0] {
      CSR_INTERVAL = 1'd0,
      CSR_GIVE_UP  = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_WAIT,
      S_POLL_RD,
      S_APPEND,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

/* design/arq_retransmit_queue.sv */
// ----------------------------------------------------------------------------
// ARQ retransmit queue
// Ordered store of unacknowledged frames with send, ack, close and poll.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel takes one command transaction: tuser carries the mode, tdata
//  carries channel, frame_number, frame_tag and now. rsp_ channel returns
//  exactly one result transaction per command: tuser carries the status,
//  tdata the resent frame, round trip, purged count and occupancy.
//  csr_ writes retransmit_interval (index 0) and give_up_limit (index 1).
//  Entries live in a ring held in a memory with one write and one
//  registered read port. A single read/compare/copy unit walks the ring.
//  Steps from command acceptance to the result: send goes through append,
//  poll through a head read and append, ack and close through one read
//  step and one compare/compact step per live entry, then the closing step;
//  each then presents its result. req_tready rises in the cycle after the
//  result is taken. The block holds req_tready low while
//  busy. The result waits in an output register; a stalled receiver holds
//  the result and the block accepts nothing new until it is taken.
//  Reset empties the queue (head pointer and count) and restores the
//  register reset values; memory contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module arq_retransmit_queue #(
   parameter int unsigned QUEUE_DEPTH = arq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tuser: mode[1:0]
   input  wire logic [1:0]   req_tuser,
   // tdata: channel[15:0], frame_number[31:16], frame_tag[47:32], now[79:48]
   input  wire logic [79:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tuser: status[2:0]
   output logic [2:0]        rsp_tuser,
   // tdata: out_channel[15:0], out_number[31:16], out_tag[47:32],
   // round_trip[79:48], purged_count[85:80], occupancy[91:86],
   // zero fill [95:92]
   output logic [95:0]       rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [0:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned EW = 112;

   // entry word: channel[15:0], number[31:16], tag[47:32], first[79:48],
   // last[111:80]
   logic [EW-1:0] mem [QUEUE_DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   logic [31:0] interval_ff, give_up_ff;
   arq_pkg::state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;    // entries read so far
   logic [CW-1:0] kept_ff, kept_in;  // entries written back so far
   logic          found_ff, found_in;
   // command word: mode in the low bits, then the tdata fields
   logic [81:0]   cmd_ff;
   // result word: status in the low bits, then the tdata fields
   logic [94:0]   rsp_ff, rsp_in;

   wire logic [1:0]  c_mode  = cmd_ff[1:0];
   wire logic [15:0] c_chan  = cmd_ff[17:2];
   wire logic [15:0] c_num   = cmd_ff[33:18];
   wire logic [15:0] c_tag   = cmd_ff[49:34];
   wire logic [31:0] c_now   = cmd_ff[81:50];

   function automatic logic [AW-1:0] wrap(input logic [AW-1:0] b, input logic [CW-1:0] o);
      logic [AW:0] s;
      s = {1'b0, b} + (AW+1)'(o);
      if (s >= (AW+1)'(QUEUE_DEPTH)) s = s - (AW+1)'(QUEUE_DEPTH);
      return s[AW-1:0];
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == arq_pkg::S_IDLE);
   assign rsp_tvalid = (state_ff == arq_pkg::S_DONE);
   assign rsp_tuser  = rsp_ff[2:0];
   assign rsp_tdata  = {4'b0000, rsp_ff[94:3]};

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= arq_pkg::RESET_INTERVAL;
         give_up_ff  <= arq_pkg::RESET_GIVE_UP;
      end else if (csr_valid) begin
         unique case (arq_pkg::csr_index_type'(csr_index))
            arq_pkg::CSR_INTERVAL: interval_ff <= csr_data;
            arq_pkg::CSR_GIVE_UP:  give_up_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arq_pkg::S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      idx_ff   <= idx_in;
      kept_ff  <= kept_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
      if (req_tvalid && req_tready) cmd_ff <= {req_tdata, req_tuser};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         arq_pkg::S_IDLE:
            if (req_tvalid) begin
               unique case (arq_pkg::mode_type'(req_tuser))
                  arq_pkg::MODE_SEND: state_in = arq_pkg::S_APPEND;
                  arq_pkg::MODE_POLL: state_in = arq_pkg::S_POLL_RD;
                  default:            state_in = arq_pkg::S_SCAN;
               endcase
            end
         arq_pkg::S_SCAN:
            if (idx_ff == count_ff) state_in = arq_pkg::S_DONE;
            else state_in = arq_pkg::S_SCAN_WAIT;
         arq_pkg::S_SCAN_WAIT: state_in = arq_pkg::S_SCAN;
         arq_pkg::S_POLL_RD:   state_in = arq_pkg::S_APPEND;
         arq_pkg::S_APPEND:    state_in = arq_pkg::S_DONE;
         arq_pkg::S_DONE:      if (rsp_tready) state_in = arq_pkg::S_IDLE;
         default:              state_in = arq_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   logic        match;
   logic [31:0] age_last, age_first;
   logic [CW-1:0] purged;
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      kept_in  = kept_ff;
      found_in = found_ff;
      rsp_in   = rsp_ff;
      rd_addr  = wrap(head_ff, idx_ff);
      wr_en    = 1'b0;
      wr_addr  = wrap(head_ff, kept_ff);
      wr_data  = rd_data_ff;
      age_last  = c_now - rd_data_ff[111:80];
      age_first = c_now - rd_data_ff[79:48];
      purged    = idx_ff - kept_ff;
      if (c_mode == arq_pkg::MODE_ACK)
         match = !found_ff && rd_data_ff[15:0] == c_chan && rd_data_ff[31:16] == c_num;
      else
         match = rd_data_ff[15:0] == c_chan;
      unique case (state_ff)
         arq_pkg::S_IDLE: begin
            idx_in   = '0;
            kept_in  = '0;
            found_in = 1'b0;
            rd_addr  = head_ff;
         end
         arq_pkg::S_SCAN: begin
            // issue read of entry idx; at end, build response
            if (idx_ff == count_ff) begin
               count_in = kept_ff;
               rsp_in = '0;
               rsp_in[94:89] = 6'(kept_ff);
               if (c_mode == arq_pkg::MODE_ACK) begin
                  rsp_in[2:0] = found_ff ? arq_pkg::ST_ACKED : arq_pkg::ST_MISSING;
                  rsp_in[82:51] = rsp_ff[82:51];
                  if (!found_ff) rsp_in[82:51] = '0;
               end else begin
                  rsp_in[2:0] = arq_pkg::ST_PURGED;
                  rsp_in[88:83] = 6'(purged);
               end
            end
            if (idx_ff == '0) rsp_in[82:51] = '0;
         end
         arq_pkg::S_SCAN_WAIT: begin
            // rd_data_ff holds entry idx
            idx_in = idx_ff + 1'b1;
            if (match) begin
               if (c_mode == arq_pkg::MODE_ACK) begin
                  found_in = 1'b1;
                  rsp_in[82:51] = age_last;
               end
            end else begin
               wr_en   = 1'b1;
               kept_in = kept_ff + 1'b1;
            end
         end
         arq_pkg::S_POLL_RD: rd_addr = head_ff;
         arq_pkg::S_APPEND: begin
            rsp_in = '0;
            if (c_mode == arq_pkg::MODE_SEND) begin
               if (count_ff == CW'(QUEUE_DEPTH)) begin
                  rsp_in[2:0] = arq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = wrap(head_ff, count_ff);
                  wr_data  = {c_now, c_now, c_tag, c_num, c_chan};
                  count_in = count_ff + 1'b1;
                  rsp_in[2:0] = arq_pkg::ST_QUEUED;
               end
            end else if (count_ff != '0 && age_last > interval_ff) begin
               rsp_in[18:3]  = rd_data_ff[15:0];
               rsp_in[34:19] = rd_data_ff[31:16];
               rsp_in[50:35] = rd_data_ff[47:32];
               head_in = wrap(head_ff, CW'(1));
               if (age_first < give_up_ff) begin
                  // rotate: head entry is copied to the free slot past the tail
                  wr_en   = 1'b1;
                  wr_addr = wrap(head_ff, count_ff);
                  wr_data = {c_now, rd_data_ff[79:0]};
                  rsp_in[2:0] = arq_pkg::ST_RESEND;
               end else begin
                  count_in = count_ff - 1'b1;
                  rsp_in[2:0] = arq_pkg::ST_RESEND_LAST;
               end
            end else begin
               rsp_in[2:0] = arq_pkg::ST_IDLE;
            end
            rsp_in[94:89] = 6'(count_in);
         end
         arq_pkg::S_DONE: ;
         default: ;
      endcase
   end
endmodule
`default_nettype wire
